// ===== design/sfdcd_pkg.sv =====
// Package for the sensor frame decoder: codes, key ROM and CRC step.
package sfdcd_pkg;

	localparam int MAX_FRAME_BYTES = 128;
	localparam int ADDR_W = 4;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'h1d0f;

	localparam logic [7:0] LEN_TEMP   = 8'h10;
	localparam logic [7:0] LEN_PERIOD = 8'h3d;
	localparam logic [7:0] LEN_STATUS = 8'h1f;
	localparam logic [7:0] LEN_PING   = 8'h1c;

	localparam logic [7:0] MARK_TEMP   = 8'h11;
	localparam logic [7:0] MARK_PERIOD = 8'h1b;
	localparam logic [7:0] MARK_STATUS = 8'h71;
	localparam logic [7:0] MARK_PING   = 8'h70;

	localparam logic [1:0] KIND_TEMP   = 2'd0;
	localparam logic [1:0] KIND_PERIOD = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;
	localparam logic [1:0] KIND_PING   = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_UNKNOWN   = 3'd2;
	localparam logic [2:0] ST_CRC_FAIL  = 3'd3;
	localparam logic [2:0] ST_MARKER    = 3'd4;
	localparam logic [2:0] ST_TEMP_BAD  = 3'd5;

	localparam logic [1:0] REG_TEMP_OFFSET = 2'd0;
	localparam logic [1:0] REG_TEMP_MIN    = 2'd1;
	localparam logic [1:0] REG_TEMP_MAX    = 2'd2;

	localparam logic [15:0] TEMP_OFFSET_RST = 16'd33168;
	localparam logic signed [10:0] TEMP_MIN_RST = -11'sd200;
	localparam logic signed [10:0] TEMP_MAX_RST = 11'sd600;

	localparam logic [128*8-1:0] KEY_STR =
		"s6amyEvO8UslCY0eZjgc2S6APCVLgLxzFvL2Z5GWPW7fKVjy2oAU6uiKU3lZCHm62VYQQuCtgxzPgGd8UDRPVZpDRAsh5EdYq1E4j4morJ3vd6tWx8BiWOLDc2I8wKUK";

	function automatic logic [7:0] key_rom(input logic [7:0] idx);
		logic [7:0] res;
		res = 8'h00;
		if (idx < 8'd128) begin
			res = KEY_STR[8 * (127 - int'(idx)) +: 8];
		end
		return res;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [31:0] swap_halves(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

endpackage

// ===== design/sensor_frame_decrypt_check_decode.sv =====
// Top level of the sensor frame decoder: CRC check, decryption, capture, status.
//
// The input stream carries the bytes that follow a sync word, one per transfer:
// tdata holds the byte, tuser marks the length byte that opens a frame and
// tlast marks the last byte of the received row. Each frame gives one status
// transfer on the output stream, with the frame kind in tuser and the decoded
// id, battery and temperature fields in tdata. Bytes outside a frame give none.
// An input transfer is registered in the input register, then decoded into the
// output register, which holds the status for the byte that ends the frame.
// One byte is taken every cycle while the output side keeps up; the single
// byte-wide CRC step and key ROM read per byte set that rate.
// When the receiver stalls, the output register holds its result and one more
// input byte is taken into the input register before tready falls.
// Reset clears both registers, closes any open frame and loads the temperature
// registers with their defaults. The APB port holds the zero offset and the
// plausible temperature limits; write them only while no frame is in flight.
module sensor_frame_decrypt_check_decode import sfdcd_pkg::*; #(
	parameter int KEY_BYTES = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] data_byte
	input  logic              s_tuser,   // [0] frame_start
	input  logic              s_tlast,   // row_end
	output logic              m_tvalid,
	input  logic              m_tready,
	// [2:0] status, [34:3] wire_id, [66:35] device_id, [67] has_reading,
	// [75:68] battery_percent, [76] battery_good, [93:77] temp_tenths, [95:94] zero
	output logic [95:0]       m_tdata,
	output logic [1:0]        m_tuser,   // [1:0] frame_kind
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int KI_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam logic [KI_W-1:0] KEY_LAST = KI_W'(KEY_BYTES - 1);

	typedef logic [255:0][KI_W-1:0] seed_tab_t;

	function automatic seed_tab_t build_seed_tab();
		seed_tab_t tab;
		int r;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			tab[i] = KI_W'(r);
			if (r == KEY_BYTES - 1) begin
				r = 0;
			end else begin
				r = r + 1;
			end
		end
		return tab;
	endfunction

	localparam seed_tab_t SEED_TAB = build_seed_tab();

	logic [15:0]        temp_offset_q;
	logic signed [10:0] temp_min_q;
	logic signed [10:0] temp_max_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       last_s1;

	logic            in_frame_q;
	logic [7:0]      byte_index_q;
	logic [7:0]      frame_len_q;
	logic [KI_W-1:0] key_ptr_q;
	logic [15:0]     crc_q;
	logic [7:0]      crc_hi_q;
	logic [7:0]      marker_q;
	logic [31:0]     id_q;
	logic [7:0]      battery_q;
	logic [15:0]     raw_temp_q;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [1:0]  kind_q;
	logic [31:0] wire_id_q;
	logic [31:0] device_id_q;
	logic        has_reading_q;
	logic [7:0]  battery_pct_q;
	logic        battery_good_q;
	logic [16:0] temp_tenths_q;

	logic out_free;
	logic fire;

	logic [7:0] len;
	logic [7:0] idx;
	logic [7:0] d;
	logic [7:0] batt_at;
	logic [7:0] plain;
	logic       active;
	logic       known;
	logic       usable;
	logic [1:0] kind;
	logic [7:0] marker_exp;
	logic       is_seed;
	logic       is_cipher;
	logic       is_crc_hi;
	logic       is_final;

	logic               emit;
	logic [2:0]         st;
	logic [1:0]         kind_o;
	logic [31:0]        wire_o;
	logic               reading_o;
	logic signed [16:0] tenths;

	assign pready = 1'b1;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign fire = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_offset_q <= TEMP_OFFSET_RST;
			temp_min_q <= TEMP_MIN_RST;
			temp_max_q <= TEMP_MAX_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_TEMP_OFFSET: temp_offset_q <= pwdata[15:0];
				REG_TEMP_MIN:    temp_min_q <= pwdata[10:0];
				REG_TEMP_MAX:    temp_max_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TEMP_OFFSET: prdata = {16'h0000, temp_offset_q};
			REG_TEMP_MIN:    prdata = {21'h000000, temp_min_q};
			REG_TEMP_MAX:    prdata = {21'h000000, temp_max_q};
			default:         prdata = 32'h0000_0000;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			start_s1 <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	assign len = start_s1 ? byte_s1 : frame_len_q;
	assign idx = start_s1 ? 8'd0 : byte_index_q + 8'd1;
	assign d = idx - 8'd2;
	assign active = start_s1 || in_frame_q;
	assign plain = byte_s1 ^ key_rom(8'(key_ptr_q));

	always_comb begin
		known = 1'b1;
		kind = KIND_TEMP;
		marker_exp = MARK_TEMP;
		case (len)
			LEN_TEMP: begin
				kind = KIND_TEMP;
				marker_exp = MARK_TEMP;
			end
			LEN_PERIOD: begin
				kind = KIND_PERIOD;
				marker_exp = MARK_PERIOD;
			end
			LEN_STATUS: begin
				kind = KIND_STATUS;
				marker_exp = MARK_STATUS;
			end
			LEN_PING: begin
				kind = KIND_PING;
				marker_exp = MARK_PING;
			end
			default: known = 1'b0;
		endcase
	end

	assign usable = known && ({1'b0, len} + 9'd1 <= 9'(MAX_FRAME_BYTES));
	assign batt_at = (kind == KIND_TEMP) ? 8'd6 : 8'd5;
	assign is_seed = (idx == 8'd1);
	assign is_cipher = (idx >= 8'd2) && ({1'b0, idx} + 9'd2 <= {1'b0, len});
	assign is_crc_hi = !is_seed && !is_cipher && ({1'b0, idx} + 9'd1 == {1'b0, len});
	assign is_final = !is_seed && !is_cipher && !is_crc_hi && (idx == len);
	assign tenths = $signed(17'({1'b0, raw_temp_q}) - 17'({1'b0, temp_offset_q}));
	assign wire_o = (kind == KIND_PING) ? swap_halves(id_q) : id_q;

	always_comb begin
		emit = 1'b0;
		st = ST_OK;
		kind_o = KIND_TEMP;
		reading_o = 1'b0;
		if (!active) begin
			emit = 1'b0;
		end else if (idx < 8'd3 && last_s1) begin
			emit = 1'b1;
			st = ST_SHORT;
		end else if (!usable) begin
			emit = (idx >= 8'd3);
			st = known ? ST_SHORT : ST_UNKNOWN;
		end else if (is_final) begin
			emit = 1'b1;
			kind_o = kind;
			if ({crc_hi_q, byte_s1} != crc_q) begin
				st = ST_CRC_FAIL;
			end else if (marker_q != marker_exp) begin
				st = ST_MARKER;
			end else if (kind == KIND_PING) begin
				st = ST_OK;
			end else begin
				reading_o = 1'b1;
				if (tenths < 17'(temp_min_q) || tenths > 17'(temp_max_q)) begin
					st = ST_TEMP_BAD;
				end
			end
		end else if (last_s1) begin
			emit = 1'b1;
			st = ST_SHORT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			byte_index_q <= 8'd0;
			frame_len_q <= 8'd0;
			key_ptr_q <= '0;
			crc_q <= CRC_INIT;
			crc_hi_q <= 8'd0;
			marker_q <= 8'd0;
			id_q <= 32'd0;
			battery_q <= 8'd0;
			raw_temp_q <= 16'd0;
		end else if (fire && active) begin
			byte_index_q <= idx;
			if (start_s1) begin
				frame_len_q <= byte_s1;
				crc_q <= CRC_INIT;
				crc_hi_q <= 8'd0;
				marker_q <= 8'd0;
				id_q <= 32'd0;
				battery_q <= 8'd0;
				raw_temp_q <= 16'd0;
			end
			in_frame_q <= !emit;
			if (usable && !(idx < 8'd3 && last_s1)) begin
				if (is_seed) begin
					key_ptr_q <= SEED_TAB[byte_s1];
				end else if (is_cipher) begin
					key_ptr_q <= (key_ptr_q == KEY_LAST) ? '0 : key_ptr_q + 1'b1;
					crc_q <= crc_byte(crc_q, byte_s1);
					if (d == 8'd0) begin
						marker_q <= plain;
					end else if (d <= 8'd4) begin
						id_q <= {id_q[23:0], plain};
					end
					if (kind != KIND_PING) begin
						if (d == batt_at) begin
							battery_q <= plain;
						end else if (d == batt_at + 8'd1) begin
							raw_temp_q[7:0] <= plain;
						end else if (d == batt_at + 8'd2) begin
							raw_temp_q[15:8] <= plain;
						end
					end
				end else if (is_crc_hi) begin
					crc_hi_q <= byte_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			status_q <= st;
			kind_q <= kind_o;
			if (st == ST_OK || st == ST_TEMP_BAD) begin
				wire_id_q <= wire_o;
				device_id_q <= swap_halves(wire_o);
			end else begin
				wire_id_q <= 32'd0;
				device_id_q <= 32'd0;
			end
			has_reading_q <= reading_o;
			battery_pct_q <= reading_o ? battery_q : 8'd0;
			battery_good_q <= reading_o && (battery_q != 8'd0);
			temp_tenths_q <= reading_o ? tenths : 17'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = kind_q;
	assign m_tdata = {2'b00, temp_tenths_q, battery_good_q, battery_pct_q, has_reading_q,
		device_id_q, wire_id_q, status_q};

endmodule

// ===== tb/sensor_frame_decrypt_check_decode_tb.sv =====
// Self-checking testbench for the sensor frame decoder with its own frame model.
module sensor_frame_decrypt_check_decode_tb import sfdcd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_BYTES = 128;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 160;

	localparam logic [128*8-1:0] KEY_TEXT = {
		"s6amyEvO8UslCY0e", "Zjgc2S6APCVLgLxz", "FvL2Z5GWPW7fKVjy", "2oAU6uiKU3lZCHm6",
		"2VYQQuCtgxzPgGd8", "UDRPVZpDRAsh5EdY", "q1E4j4morJ3vd6tW", "x8BiWOLDc2I8wKUK"
	};

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  kind;
		logic [31:0] wire_id;
		logic [31:0] device_id;
		logic        has_reading;
		logic [7:0]  battery;
		logic        battery_good;
		logic [16:0] tenths;
	} frame_status_t;

	typedef struct packed {
		logic [7:0]  len;
		logic [7:0]  seed;
		bit          bad_mark;
		bit          bad_crc;
		logic [31:0] id;
		logic [7:0]  batt;
		logic [15:0] raw;
		logic [7:0]  cut;
		bit          last;
		bit          pre_noise;
		bit          post_noise;
		bit          typed;
		logic [2:0]  want_st;
		logic [1:0]  want_kind;
	} frame_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = 8'h00;
	logic              s_tuser = 1'b0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [95:0]       m_tdata;
	logic [1:0]        m_tuser;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	logic [15:0]        cfg_offset = TEMP_OFFSET_RST;
	logic signed [10:0] cfg_min = TEMP_MIN_RST;
	logic signed [10:0] cfg_max = TEMP_MAX_RST;

	bit          fr_open;
	logic [7:0]  fr_idx;
	logic [7:0]  fr_len;
	logic [7:0]  fr_seed;
	logic [15:0] fr_crc;
	logic [7:0]  crc_hi;
	logic [7:0]  fr_marker;
	logic [31:0] fr_id;
	logic [7:0]  fr_batt;
	logic [15:0] fr_raw;

	frame_status_t pending_status[$];
	logic [7:0]    frame_bytes[$];
	int            error_count = 0;
	int            cycle_count = 0;
	bit            tx_idle_on = 1'b1;
	bit            rx_idle_on = 1'b1;
	bit            hold_req = 1'b0;
	int            rx_hold = 0;

	frame_row_t directed_rows [0:20] = '{
		'{LEN_TEMP, 8'h00, 0, 0, 32'h01020304, 100, 33383,
			0, 0, 1, 0, 0, ST_OK, KIND_TEMP},
		'{LEN_PERIOD, 8'h7f, 0, 0, 32'hffffffff, 255, 33768,
			0, 1, 0, 0, 0, ST_OK, KIND_PERIOD},
		'{LEN_STATUS, 8'hff, 0, 0, 32'h00000000, 0, 32968,
			0, 0, 0, 1, 0, ST_OK, KIND_STATUS},
		'{LEN_PING, 8'h80, 0, 0, 32'ha1b2c3d4, 85, 16'h1234,
			0, 0, 0, 0, 0, ST_OK, KIND_PING},
		'{LEN_TEMP, 8'h11, 0, 0, 32'hdeadbeef, 1, 33769,
			0, 0, 0, 0, 0, ST_TEMP_BAD, KIND_TEMP},
		'{LEN_PERIOD, 8'h22, 0, 0, 32'h5a5a0f0f, 50, 32967,
			0, 0, 0, 0, 0, ST_TEMP_BAD, KIND_PERIOD},
		'{LEN_STATUS, 8'h33, 0, 0, 32'h12345678, 20, 16'h0000,
			0, 0, 0, 0, 0, ST_TEMP_BAD, KIND_STATUS},
		'{LEN_TEMP, 8'h44, 0, 0, 32'h87654321, 70, 16'hffff,
			0, 0, 0, 0, 0, ST_TEMP_BAD, KIND_TEMP},
		'{LEN_TEMP, 8'h55, 0, 1, 32'h11223344, 90, 33200,
			0, 0, 0, 0, 1, ST_CRC_FAIL, KIND_TEMP},
		'{LEN_PING, 8'h66, 0, 1, 32'h55667788, 0, 0,
			0, 0, 0, 0, 1, ST_CRC_FAIL, KIND_PING},
		'{LEN_PERIOD, 8'h77, 1, 0, 32'h99aabbcc, 40, 33300,
			0, 0, 0, 0, 1, ST_MARKER, KIND_PERIOD},
		'{LEN_STATUS, 8'h88, 1, 0, 32'hddeeff00, 60, 33100,
			0, 0, 0, 0, 1, ST_MARKER, KIND_STATUS},
		'{LEN_TEMP, 8'h00, 0, 0, 32'h0, 0, 0,
			1, 1, 0, 0, 1, ST_SHORT, KIND_TEMP},
		'{LEN_PERIOD, 8'h01, 0, 0, 32'h0, 0, 0,
			3, 1, 0, 0, 1, ST_SHORT, KIND_TEMP},
		'{LEN_STATUS, 8'h02, 0, 0, 32'h01010101, 10, 33168,
			10, 1, 0, 0, 1, ST_SHORT, KIND_TEMP},
		'{LEN_PING, 8'h03, 0, 0, 32'h02020202, 0, 0,
			28, 1, 0, 0, 1, ST_SHORT, KIND_TEMP},
		'{8'h00, 8'h04, 0, 0, 32'h0, 0, 0,
			4, 0, 0, 0, 1, ST_UNKNOWN, KIND_TEMP},
		'{8'hff, 8'h05, 0, 0, 32'h0, 0, 0,
			3, 1, 0, 0, 1, ST_SHORT, KIND_TEMP},
		'{8'h20, 8'h06, 0, 0, 32'h0, 0, 0,
			7, 1, 0, 1, 1, ST_UNKNOWN, KIND_TEMP},
		'{LEN_PERIOD, 8'h07, 0, 0, 32'h03030303, 30, 33168,
			20, 0, 0, 0, 0, ST_OK, KIND_TEMP},
		'{LEN_TEMP, 8'h08, 0, 0, 32'h04030201, 99, 33170,
			0, 1, 0, 1, 0, ST_OK, KIND_TEMP}
	};

	sensor_frame_decrypt_check_decode #(
		.KEY_BYTES(KEY_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	function automatic logic [7:0] key_at(input int i);
		if (i < 128) begin
			return KEY_TEXT[8 * (127 - i) +: 8];
		end
		return 8'h00;
	endfunction

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic int kind_of(input logic [7:0] len);
		case (len)
			LEN_TEMP: return int'(KIND_TEMP);
			LEN_PERIOD: return int'(KIND_PERIOD);
			LEN_STATUS: return int'(KIND_STATUS);
			LEN_PING: return int'(KIND_PING);
			default: return -1;
		endcase
	endfunction

	function automatic logic [7:0] marker_of(input int kind);
		case (kind)
			int'(KIND_TEMP): return MARK_TEMP;
			int'(KIND_PERIOD): return MARK_PERIOD;
			int'(KIND_STATUS): return MARK_STATUS;
			default: return MARK_PING;
		endcase
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(9) == 0) begin
			return $urandom_range(40, 10);
		end
		return $urandom_range(3, 1);
	endfunction

	function automatic logic [7:0] pick_len();
		case ($urandom_range(3))
			0: return LEN_TEMP;
			1: return LEN_PERIOD;
			2: return LEN_STATUS;
			default: return LEN_PING;
		endcase
	endfunction

	function automatic logic [7:0] pick_batt();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_raw();
		int lo;
		int hi;
		if ($urandom_range(9) < 3) begin
			return 16'($urandom);
		end
		lo = int'(cfg_min) - 30;
		hi = int'(cfg_max) + 30;
		if (lo > hi) begin
			lo = int'(cfg_max) - 30;
			hi = int'(cfg_min) + 30;
		end
		return 16'(int'(cfg_offset) + lo + int'($urandom_range(hi - lo)));
	endfunction

	task automatic clear_frame();
		fr_open = 1'b0;
		fr_idx = '0;
		fr_len = '0;
		fr_seed = '0;
		fr_crc = CRC_INIT;
		crc_hi = '0;
		fr_marker = '0;
		fr_id = '0;
		fr_batt = '0;
		fr_raw = '0;
	endtask

	task automatic decode_byte(input logic [7:0] b, input bit start, input bit last,
			output bit got, output frame_status_t res);
		int idx;
		int kind;
		int d;
		int batt_at;
		int tenths;
		bit usable;
		logic [7:0] plain;
		logic [31:0] wire_val;
		got = 1'b0;
		res = '0;
		if (start) begin
			clear_frame();
			fr_open = 1'b1;
			fr_len = b;
			idx = 0;
		end else if (!fr_open) begin
			return;
		end else begin
			idx = (int'(fr_idx) + 1) % 256;
			fr_idx = 8'(idx);
		end
		kind = kind_of(fr_len);
		usable = kind >= 0 && 1 + int'(fr_len) <= MAX_FRAME_BYTES;
		if (idx < 3 && last) begin
			got = 1'b1;
			res.status = ST_SHORT;
		end else if (!usable) begin
			if (idx >= 3) begin
				got = 1'b1;
				res.status = (kind < 0) ? ST_UNKNOWN : ST_SHORT;
			end
		end else if (idx == int'(fr_len)) begin
			got = 1'b1;
			res.kind = 2'(kind);
			if ({crc_hi, b} != fr_crc) begin
				res.status = ST_CRC_FAIL;
			end else if (fr_marker != marker_of(kind)) begin
				res.status = ST_MARKER;
			end else begin
				wire_val = (kind == int'(KIND_PING)) ? {fr_id[15:0], fr_id[31:16]} : fr_id;
				res.status = ST_OK;
				res.wire_id = wire_val;
				res.device_id = {wire_val[15:0], wire_val[31:16]};
				if (kind != int'(KIND_PING)) begin
					tenths = int'(fr_raw) - int'(cfg_offset);
					if (tenths < cfg_min || tenths > cfg_max) begin
						res.status = ST_TEMP_BAD;
					end
					res.has_reading = 1'b1;
					res.battery = fr_batt;
					res.battery_good = fr_batt != 8'h00;
					res.tenths = 17'(tenths);
				end
			end
		end else begin
			if (idx == 1) begin
				fr_seed = b;
			end else if (idx >= 2 && idx + 2 <= int'(fr_len)) begin
				d = idx - 2;
				plain = b ^ key_at((d + int'(fr_seed)) % KEY_BYTES);
				batt_at = (kind == int'(KIND_TEMP)) ? 6 : 5;
				fr_crc = crc_step(fr_crc, b);
				if (d == 0) begin
					fr_marker = plain;
				end else if (d <= 4) begin
					fr_id = {fr_id[23:0], plain};
				end
				if (kind != int'(KIND_PING)) begin
					if (d == batt_at) begin
						fr_batt = plain;
					end else if (d == batt_at + 1) begin
						fr_raw[7:0] = plain;
					end else if (d == batt_at + 2) begin
						fr_raw[15:8] = plain;
					end
				end
			end else if (idx + 1 == int'(fr_len)) begin
				crc_hi = b;
			end
			if (last) begin
				got = 1'b1;
				res.status = ST_SHORT;
			end
		end
		if (got) begin
			fr_open = 1'b0;
		end
	endtask

	// Builds the wire bytes of one frame: length, seed, ciphertext, then CRC high and low.
	task automatic build_frame(input logic [7:0] len, input logic [7:0] seed, input bit bad_mark,
			input bit bad_crc, input logic [31:0] id, input logic [7:0] batt,
			input logic [15:0] raw, input int cut);
		int kind;
		int n;
		int batt_at;
		logic [7:0] plain [0:63];
		logic [7:0] c;
		logic [15:0] crc;
		frame_bytes = {};
		frame_bytes.push_back(len);
		frame_bytes.push_back(seed);
		kind = kind_of(len);
		if (kind < 0) begin
			while (frame_bytes.size() < cut) begin
				frame_bytes.push_back(8'($urandom));
			end
		end else begin
			n = int'(len) - 3;
			for (int d = 0; d < n; d++) begin
				plain[d] = 8'($urandom);
			end
			plain[0] = marker_of(kind) ^ (bad_mark ? 8'($urandom_range(255, 1)) : 8'h00);
			{plain[1], plain[2], plain[3], plain[4]} = id;
			if (kind != int'(KIND_PING)) begin
				batt_at = (kind == int'(KIND_TEMP)) ? 6 : 5;
				plain[batt_at] = batt;
				plain[batt_at + 1] = raw[7:0];
				plain[batt_at + 2] = raw[15:8];
			end
			crc = CRC_INIT;
			for (int d = 0; d < n; d++) begin
				c = plain[d] ^ key_at((d + int'(seed)) % KEY_BYTES);
				crc = crc_step(crc, c);
				frame_bytes.push_back(c);
			end
			if (bad_crc) begin
				crc ^= 16'($urandom_range(65535, 1));
			end
			frame_bytes.push_back(crc[15:8]);
			frame_bytes.push_back(crc[7:0]);
		end
		while (cut > 0 && frame_bytes.size() > cut) begin
			void'(frame_bytes.pop_back());
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input bit start, input bit last,
			input bit typed, input frame_status_t typed_res);
		int gap;
		bit got;
		frame_status_t res;
		gap = (tx_idle_on && $urandom_range(99) < 25) ? pick_gap() : 0;
		repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= start;
		s_tlast <= last;
		decode_byte(b, start, last, got, res);
		if (got) begin
			pending_status.push_back(typed ? typed_res : res);
		end
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_frame(input bit last_on_end, input bit typed,
			input frame_status_t typed_res);
		for (int i = 0; i < frame_bytes.size(); i++) begin
			send_byte(frame_bytes[i], i == 0, last_on_end && i == frame_bytes.size() - 1,
				typed, typed_res);
		end
	endtask

	task automatic send_noise(input int count);
		repeat (count) send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)), 1'b0, '0);
	endtask

	// Closes any open frame, lets every status transfer come out, then waits out the pipeline.
	task automatic drain_block();
		if (fr_open) begin
			send_byte(8'h00, 1'b1, 1'b1, 1'b0, '0);
		end
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx));
		pwdata <= val;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TEMP_OFFSET: cfg_offset = val[15:0];
			REG_TEMP_MIN: cfg_min = val[10:0];
			REG_TEMP_MAX: cfg_max = val[10:0];
			default: ;
		endcase
	endtask

	task automatic random_frames(input int target);
		int sent;
		int sel;
		logic [7:0] len;
		sent = 0;
		while (sent < target) begin
			sel = $urandom_range(99);
			len = pick_len();
			if (sel >= 95) begin
				send_noise($urandom_range(4, 1));
			end else if (sel >= 88) begin
				do len = 8'($urandom); while (kind_of(len) >= 0);
				build_frame(len, 8'($urandom), 1'b0, 1'b0, '0, '0, '0, $urandom_range(8, 1));
				send_frame(1'($urandom_range(1)), 1'b0, '0);
				sent += frame_bytes.size();
			end else begin
				build_frame(len, 8'($urandom), sel >= 6 && sel < 12, sel < 6, $urandom,
					pick_batt(), pick_raw(), (sel < 75) ? 0 : $urandom_range(int'(len), 1));
				send_frame(sel < 83 ? 1'($urandom_range(1)) : 1'b0, 1'b0, '0);
				sent += frame_bytes.size();
			end
			if ($urandom_range(4) == 0) begin
				send_noise($urandom_range(3, 1));
			end
		end
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		$display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			rx_hold = LONG_HOLD;
		end
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else if (!rx_idle_on || $urandom_range(99) < 75) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b0;
			rx_hold = pick_gap() - 1;
		end
	end

	always @(posedge clk) begin : check_status
		frame_status_t got;
		frame_status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tdata[2:0];
			got.kind = m_tuser;
			got.wire_id = m_tdata[34:3];
			got.device_id = m_tdata[66:35];
			got.has_reading = m_tdata[67];
			got.battery = m_tdata[75:68];
			got.battery_good = m_tdata[76];
			got.tenths = m_tdata[93:77];
			if (pending_status.size() == 0) begin
				report_mismatch("unexpected status transfer", 32'(got.status), '0);
			end else begin
				want = pending_status.pop_front();
				if (got.status != want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.kind != want.kind)
					report_mismatch("frame_kind", 32'(got.kind), 32'(want.kind));
				if (got.wire_id != want.wire_id)
					report_mismatch("wire_id", got.wire_id, want.wire_id);
				if (got.device_id != want.device_id)
					report_mismatch("device_id", got.device_id, want.device_id);
				if (got.has_reading != want.has_reading)
					report_mismatch("has_reading", 32'(got.has_reading), 32'(want.has_reading));
				if (got.battery != want.battery)
					report_mismatch("battery_percent", 32'(got.battery), 32'(want.battery));
				if (got.battery_good != want.battery_good)
					report_mismatch("battery_good", 32'(got.battery_good),
						32'(want.battery_good));
				if (got.tenths != want.tenths)
					report_mismatch("temp_tenths", 32'(got.tenths), 32'(want.tenths));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		frame_row_t row;
		frame_status_t typed_res;
		int off;
		int lo;
		int hi;
		int tmp;
		clear_frame();
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.pre_noise) begin
				send_noise(3);
			end
			build_frame(row.len, row.seed, row.bad_mark, row.bad_crc, row.id, row.batt, row.raw,
				int'(row.cut));
			typed_res = '0;
			typed_res.status = row.want_st;
			typed_res.kind = row.want_kind;
			send_frame(row.last, row.typed, typed_res);
			if (row.post_noise) begin
				send_noise(3);
			end
		end

		for (int p = 0; p < 6; p++) begin
			drain_block();
			off = $urandom_range(65535);
			lo = int'($urandom_range(2000)) - 1000;
			hi = int'($urandom_range(2000)) - 1000;
			if (lo > hi) begin
				tmp = lo;
				lo = hi;
				hi = tmp;
			end
			case (p)
				0: begin off = 0; lo = -1000; hi = 1000; end
				1: begin off = 65535; lo = -1000; hi = 1000; end
				3: begin off = int'(TEMP_OFFSET_RST); lo = 1000; hi = -1000; end
				default: ;
			endcase
			write_reg(REG_TEMP_OFFSET, 32'(off));
			write_reg(REG_TEMP_MIN, 32'(lo));
			write_reg(REG_TEMP_MAX, 32'(hi));
			tx_idle_on = !(p == 1 || p == 4);
			rx_idle_on = p != 4;
			// The receiver stalls for a long stretch while transfers keep coming.
			if (p == 1) begin
				hold_req = 1'b1;
			end
			random_frames(PHASE_ITEMS);
		end

		drain_block();
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
